// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication that also checks during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/udpg_pkg.sv -----
// ----------------------------------------------------------------------------
// udpg_pkg
// Constants, types and checksum helpers for the UDP/IPv4 header generator.
// ----------------------------------------------------------------------------
package udpg_pkg;

  localparam int LEN_W   = 11;
  localparam int WORD_W  = 16;
  localparam int ACC_W   = 19;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam int ETH_HDR_BYTES = 14;
  localparam int IP_HDR_BYTES  = 20;
  localparam int UDP_HDR_BYTES = 8;
  localparam int HDR_BYTES     = ETH_HDR_BYTES + IP_HDR_BYTES + UDP_HDR_BYTES;

  localparam logic [WORD_W-1:0] PROTO_UDP     = 16'h0011;
  localparam logic [WORD_W-1:0] IP_VER_TOS    = 16'h4510;
  localparam logic [WORD_W-1:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [WORD_W-1:0] IP_TTL_PROTO  = 16'h4011;
  localparam logic [WORD_W-1:0] IDENT_INIT    = 16'h0001;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 2'd3;

  localparam int OUT_DATA_W = 72;

  // Result payload, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic [WORD_W-1:0] udp_sum;
    logic [LEN_W-1:0]  udp_length;
    logic [WORD_W-1:0] ip_header_sum;
    logic [WORD_W-1:0] ip_ident;
    logic [LEN_W-1:0]  ip_total_length;
  } out_fields_t;

  // End-around-carry fold of a multi-term sum down to 16 bits.
  function automatic logic [WORD_W-1:0] oc_fold(input logic [ACC_W-1:0] t);
    logic [WORD_W:0] s;
    logic [WORD_W:0] s2;
    s  = {1'b0, t[WORD_W-1:0]} + {14'd0, t[ACC_W-1:WORD_W]};
    s2 = {1'b0, s[WORD_W-1:0]} + {16'd0, s[WORD_W]};
    return s2[WORD_W-1:0];
  endfunction

  // Two-operand ones'-complement add.
  function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {15'd0, s[WORD_W]};
  endfunction

endpackage

// ----- rtl/core/udp_ipv4_header_generator.sv -----
// ----------------------------------------------------------------------------
// udp_ipv4_header_generator
// Computes IPv4/UDP lengths, identification and checksums from a payload stream.
// ----------------------------------------------------------------------------
// Payload bytes stream in one per request, at one request per clock. Each
// byte passes an input register, then a single stage folds it into the
// running ones'-complement sum; on the request marked tlast the same stage
// forms both checksums and loads the result register, so the result shows
// on out_* from the result register. A tlast request
// waits in the input register while an earlier result is still unaccepted,
// and the input stalls behind it. The rate is set by the 16-bit
// end-around-carry add in that stage. Address and port partial sums are
// registered from the configuration registers. A payload longer than
// MAX_FRAME_BYTES - 42 bytes returns a result with out_tuser set and all
// data zero, and the identification does not advance.
module udp_ipv4_header_generator #(
  parameter int MAX_FRAME_BYTES = 1514
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [10:0] ip_total_length, [26:11] ip_ident,
                                  // [42:27] ip_header_sum, [53:43] udp_length,
                                  // [69:54] udp_sum, [71:70] zero
  output logic        out_tuser   // [0] too_large
);

  localparam int LW = udpg_pkg::LEN_W;
  localparam int WW = udpg_pkg::WORD_W;
  localparam int AW = udpg_pkg::ACC_W;
  localparam int PAYLOAD_LIMIT = MAX_FRAME_BYTES - udpg_pkg::HDR_BYTES;
  localparam logic [LW-1:0] LIMIT = LW'(PAYLOAD_LIMIT);
  localparam logic [LW-1:0] UDP_HDR = LW'(udpg_pkg::UDP_HDR_BYTES);
  localparam logic [LW-1:0] IPUDP_HDR =
    LW'(udpg_pkg::UDP_HDR_BYTES + udpg_pkg::IP_HDR_BYTES);

  // configuration
  logic [31:0]   src_ip_r, dst_ip_r;
  logic [WW-1:0] src_port_r, dst_port_r;
  logic [WW-1:0] addr_sum_r, port_sum_r;
  logic [WW-1:0] addr_sum_nxt, port_sum_nxt;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_present_r;
  logic       s1_last_r;

  // packet state
  logic [WW-1:0] run_sum_r, run_sum_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          ovf_r, ovf_nxt;
  logic [WW-1:0] ident_r;

  // result register
  logic                  out_valid_r;
  udpg_pkg::out_fields_t out_data_r, out_data_nxt;
  logic                  out_tl_r;

  logic          out_free, s1_fire, s1_done;
  logic          take_byte, ovf_hit, ovf_fin;
  logic [WW-1:0] tail_word;
  logic [LW-1:0] count_fin, udp_len, ip_len;
  logic [AW-1:0] udp_acc, ip_acc;
  logic [WW-1:0] udp_ck, ip_ck;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ip_r   <= '0;
      dst_ip_r   <= '0;
      src_port_r <= '0;
      dst_port_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udpg_pkg::CFG_SRC_IP:   src_ip_r   <= cfg_wdata;
        udpg_pkg::CFG_DST_IP:   dst_ip_r   <= cfg_wdata;
        udpg_pkg::CFG_SRC_PORT: src_port_r <= cfg_wdata[WW-1:0];
        udpg_pkg::CFG_DST_PORT: dst_port_r <= cfg_wdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    addr_sum_nxt = udpg_pkg::oc_fold(AW'(src_ip_r[31:16]) + AW'(src_ip_r[15:0]) +
                                     AW'(dst_ip_r[31:16]) + AW'(dst_ip_r[15:0]));
    port_sum_nxt = udpg_pkg::oc_fold(AW'(src_ip_r[31:16]) + AW'(src_ip_r[15:0]) +
                                     AW'(dst_ip_r[31:16]) + AW'(dst_ip_r[15:0]) +
                                     AW'(src_port_r) + AW'(dst_port_r) +
                                     AW'(udpg_pkg::PROTO_UDP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_sum_r <= '0;
      port_sum_r <= udpg_pkg::PROTO_UDP;
    end else begin
      addr_sum_r <= addr_sum_nxt;
      port_sum_r <= port_sum_nxt;
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign s1_done   = s1_fire && s1_last_r;
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata;
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  // byte accumulation and result forming
  always_comb begin
    take_byte = s1_present_r && !ovf_r && (count_r < LIMIT);
    ovf_hit   = s1_present_r && !ovf_r && (count_r >= LIMIT);
    ovf_fin   = ovf_r || ovf_hit;

    run_sum_nxt = run_sum_r;
    hold_nxt    = hold_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_fin;
    if (take_byte) begin
      if (count_r[0]) begin
        run_sum_nxt = udpg_pkg::oc_add(run_sum_r, {hold_r, s1_byte_r});
      end else begin
        hold_nxt = s1_byte_r;
      end
      count_nxt = count_r + LW'(1);
    end

    // word still outside the running sum at packet end, odd byte zero-padded
    priority if (take_byte && count_r[0]) begin
      tail_word = {hold_r, s1_byte_r};
    end else if (take_byte) begin
      tail_word = {s1_byte_r, 8'h00};
    end else if (count_r[0]) begin
      tail_word = {hold_r, 8'h00};
    end else begin
      tail_word = '0;
    end

    count_fin = count_r + LW'(take_byte);
    udp_len   = count_fin + UDP_HDR;
    ip_len    = count_fin + IPUDP_HDR;

    udp_acc = AW'(run_sum_r) + AW'(tail_word) + AW'(port_sum_r) +
              AW'({udp_len, 1'b0});
    ip_acc  = AW'(AW'(udpg_pkg::IP_VER_TOS) + AW'(udpg_pkg::IP_FLAGS_DF) +
                  AW'(udpg_pkg::IP_TTL_PROTO)) +
              AW'(addr_sum_r) + AW'(ip_len) + AW'(ident_r);
    udp_ck  = ~udpg_pkg::oc_fold(udp_acc);
    ip_ck   = ~udpg_pkg::oc_fold(ip_acc);

    out_data_nxt = '0;
    if (!ovf_fin) begin
      out_data_nxt.ip_total_length = ip_len;
      out_data_nxt.ip_ident        = ident_r;
      out_data_nxt.ip_header_sum   = ip_ck;
      out_data_nxt.udp_length      = udp_len;
      out_data_nxt.udp_sum         = (udp_ck == '0) ? '1 : udp_ck;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r <= '0;
      count_r   <= '0;
      hold_r    <= '0;
      ovf_r     <= 1'b0;
      ident_r   <= udpg_pkg::IDENT_INIT;
    end else if (s1_done) begin
      run_sum_r <= '0;
      count_r   <= '0;
      hold_r    <= '0;
      ovf_r     <= 1'b0;
      if (!ovf_fin) begin
        ident_r <= ident_r + WW'(1);
      end
    end else if (s1_fire) begin
      run_sum_r <= run_sum_nxt;
      count_r   <= count_nxt;
      hold_r    <= hold_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_data_r <= out_data_nxt;
      out_tl_r   <= ovf_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_tl_r;

endmodule

// ----- rtl/core/udpg_checker.sv -----
// ----------------------------------------------------------------------------
// udpg_checker
// Port-level checks for the UDP/IPv4 header generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  logic [10:0] ip_len;
  logic [10:0] udp_len;
  logic [15:0] udp_ck;

  assign ip_len  = out_tdata[10:0];
  assign udp_len = out_tdata[53:43];
  assign udp_ck  = out_tdata[69:54];

  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid)
  `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `ASSERT_IMPLY(a_oversize_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `ASSERT_IMPLY(a_len_match, clk, rst_n, out_tvalid && !out_tuser,
                ip_len == udp_len + 11'd20)
  `ASSERT_IMPLY(a_udp_ck_nonzero, clk, rst_n, out_tvalid && !out_tuser, udp_ck != '0)

endmodule

bind udp_ipv4_header_generator udpg_checker u_udpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/udp_ipv4_header_generator_tb.sv -----
// ----------------------------------------------------------------------------
// udp_ipv4_header_generator_tb
// Self-checking testbench for the UDP/IPv4 header generator. A table of
// directed packets runs first: reset values, byte extremes, odd and even
// lengths, empty items and empty packets, the exact payload limit, oversize
// payloads and a UDP checksum that folds to zero. Random packets follow under
// several address and port settings, among them a run of back-to-back empty
// packets. Each result is checked field by field against the row's typed
// result if given, else a local header predictor. Both stream sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module udp_ipv4_header_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX   = 1514;
  localparam int PAYLOAD_MAX = FRAME_MAX - udpg_pkg::HDR_BYTES;
  localparam int LW          = udpg_pkg::LEN_W;
  localparam int WW          = udpg_pkg::WORD_W;

  typedef struct {
    logic [LW-1:0] ip_total_length;
    logic [WW-1:0] ip_ident;
    logic [WW-1:0] ip_header_sum;
    logic [LW-1:0] udp_length;
    logic [WW-1:0] udp_sum;
    logic          too_large;
  } hdr_result_t;

  typedef struct {
    int unsigned n;
    logic [7:0]  first;
    logic [7:0]  step;
    bit          empty_tail;
    bit          gaps;
    bit          typed;
    hdr_result_t want;
  } pkt_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] payload_byte
  logic        in_tuser;   // [0] byte_present
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [10:0] ip_total_length, [26:11] ip_ident,
                           // [42:27] ip_header_sum, [53:43] udp_length,
                           // [69:54] udp_sum, [71:70] zero
  logic        out_tuser;  // [0] too_large

  udp_ipv4_header_generator #(.MAX_FRAME_BYTES(FRAME_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state and register shadow
  logic [31:0]   src_ip_q, dst_ip_q;
  logic [15:0]   src_port_q, dst_port_q;
  logic [15:0]   ident_q;
  logic [15:0]   acc_q;
  logic [LW-1:0] nbytes_q;
  logic [7:0]    hi_q;
  bit            over_q;

  hdr_result_t pending_hdrs[$];
  hdr_result_t typed_res;
  bit          typed_on;
  bit          quiet;
  int          err_cnt, items_sent, pkt_cnt, over_cnt, wraps, hdrs_seen, cfg_sets;
  pkt_row_t    dir_rows[12];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    t = {1'b0, t[15:0]} + {16'd0, t[16]};
    return t[15:0];
  endfunction

  function automatic logic [15:0] ones_add32(input logic [15:0] a, input logic [31:0] v);
    return ones_add(ones_add(a, v[31:16]), v[15:0]);
  endfunction

  task automatic predict_header(input logic [7:0] b, input bit present, input bit last,
                                output bit has, output hdr_result_t r);
    logic [15:0]   s;
    logic [LW-1:0] ul, il;
    has = 0;
    r = '{default: '0};
    if (present && !over_q) begin
      if (nbytes_q >= PAYLOAD_MAX) begin
        over_q = 1;
      end else begin
        if (!nbytes_q[0]) hi_q = b;
        else acc_q = ones_add(acc_q, {hi_q, b});
        nbytes_q = nbytes_q + 1'b1;
      end
    end
    if (last) begin
      has = 1;
      if (over_q) begin
        r.too_large = 1'b1;
      end else begin
        ul = nbytes_q + LW'(udpg_pkg::UDP_HDR_BYTES);
        il = nbytes_q + LW'(udpg_pkg::UDP_HDR_BYTES + udpg_pkg::IP_HDR_BYTES);
        s = ones_add(udpg_pkg::IP_VER_TOS, {5'd0, il});
        s = ones_add(s, ident_q);
        s = ones_add(s, udpg_pkg::IP_FLAGS_DF);
        s = ones_add(s, udpg_pkg::IP_TTL_PROTO);
        s = ones_add32(s, src_ip_q);
        s = ones_add32(s, dst_ip_q);
        r.ip_header_sum = ~s;
        s = acc_q;
        if (nbytes_q[0]) s = ones_add(s, {hi_q, 8'h00});
        s = ones_add(s, src_port_q);
        s = ones_add(s, dst_port_q);
        s = ones_add(s, {5'd0, ul});
        s = ones_add32(s, src_ip_q);
        s = ones_add32(s, dst_ip_q);
        s = ones_add(s, udpg_pkg::PROTO_UDP);
        s = ones_add(s, {5'd0, ul});
        r.udp_sum = (~s == 16'h0000) ? 16'hFFFF : ~s;
        r.ip_total_length = il;
        r.udp_length = ul;
        r.ip_ident = ident_q;
        ident_q = ident_q + 1'b1;
        if (ident_q == 16'h0000) wraps++;
      end
      acc_q = '0;
      nbytes_q = '0;
      hi_q = '0;
      over_q = 0;
    end
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // entered and left just after a rising edge
  task automatic send_item(input logic [7:0] b, input bit present, input bit last);
    bit          ok;
    bit          has;
    hdr_result_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= last;
    ok = 0;
    while (!ok) begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end
    predict_header(b, present, last, has, r);
    if (has) begin
      if (typed_on) r = typed_res;
      pending_hdrs.push_back(r);
      pkt_cnt++;
      if (r.too_large) over_cnt++;
    end
    if (present) items_sent++;
  endtask

  task automatic send_packet(input int n, input bit rnd, input logic [7:0] first,
                             input logic [7:0] step, input bit empty_tail, input bit gaps);
    logic [7:0] b, k;
    for (int i = 0; i < n; i++) begin
      if (gaps && (rnd ? ($urandom_range(0, 9) == 0) : (i < 2)))
        send_item(8'($urandom), 1'b0, 1'b0);
      k = i[7:0];
      b = rnd ? 8'($urandom) : 8'(first + step * k);
      send_item(b, 1'b1, (i == n - 1) && !empty_tail);
    end
    if (n == 0 || empty_tail) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_hdrs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      udpg_pkg::CFG_SRC_IP:   src_ip_q   = v;
      udpg_pkg::CFG_DST_IP:   dst_ip_q   = v;
      udpg_pkg::CFG_SRC_PORT: src_port_q = v[15:0];
      default:                dst_port_q = v[15:0];
    endcase
  endtask

  task automatic load_settings(input logic [31:0] sip, input logic [31:0] dip,
                               input logic [31:0] sp, input logic [31:0] dp);
    settle();
    write_cfg(udpg_pkg::CFG_SRC_IP, sip);
    write_cfg(udpg_pkg::CFG_DST_IP, dip);
    write_cfg(udpg_pkg::CFG_SRC_PORT, sp);
    write_cfg(udpg_pkg::CFG_DST_PORT, dp);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_sets++;
  endtask

  task automatic run_random(input int target);
    int start, n;
    bit long_done;
    start = items_sent;
    long_done = 0;
    while (items_sent - start < target) begin
      if (!long_done && $urandom_range(0, 29) == 0) begin
        n = $urandom_range(PAYLOAD_MAX - 8, PAYLOAD_MAX + 8);
        long_done = 1;
        start += n;
      end else if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(16, 80);
      end else begin
        n = $urandom_range(0, 15);
      end
      send_packet(n, 1'b1, 8'h00, 8'h00, $urandom_range(0, 3) == 0, 1'b1);
    end
  endtask

  // result side: ready with random bursts of back-pressure, one long hold-off
  initial begin
    udpg_pkg::out_fields_t got;
    hdr_result_t want;
    int          stall_left;
    bit          held;
    stall_left = 0;
    held = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata;
        hdrs_seen++;
        if (pending_hdrs.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else begin
          want = pending_hdrs.pop_front();
          compare_field("ip_total_length", want.ip_total_length, got.ip_total_length);
          compare_field("ip_ident", want.ip_ident, got.ip_ident);
          compare_field("ip_header_sum", want.ip_header_sum, got.ip_header_sum);
          compare_field("udp_length", want.udp_length, got.udp_length);
          compare_field("udp_sum", want.udp_sum, got.udp_sum);
          compare_field("too_large", want.too_large, out_tuser);
        end
      end
      @(posedge clk);
      if (!held && hdrs_seen >= 20) begin
        held = 1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= udpg_pkg::CFG_SRC_IP;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    src_ip_q = '0; dst_ip_q = '0; src_port_q = '0; dst_port_q = '0;
    ident_q = udpg_pkg::IDENT_INIT; acc_q = '0; nbytes_q = '0; hi_q = '0; over_q = 0;
    typed_on = 0; quiet = 0;
    err_cnt = 0; items_sent = 0; pkt_cnt = 0; over_cnt = 0; wraps = 0;
    hdrs_seen = 0; cfg_sets = 0;

    //             n     first  step   etail gaps typed expected
    dir_rows[0]  = '{0,    8'h00, 8'h00, 1, 0, 1, '{11'd28, 16'd1, 16'h3AC1, 11'd8, 16'hFFDE, 0}};
    // two bytes that fold the UDP sum to zero, sent as all ones
    dir_rows[1]  = '{2,    8'hFF, 8'hDB, 0, 0, 1, '{11'd30, 16'd2, 16'h3ABE, 11'd10, 16'hFFFF, 0}};
    dir_rows[2]  = '{1,    8'hFF, 8'h00, 0, 0, 0, '{default: '0}};
    dir_rows[3]  = '{2,    8'hFF, 8'h00, 1, 0, 0, '{default: '0}};
    dir_rows[4]  = '{3,    8'h00, 8'h00, 0, 1, 0, '{default: '0}};
    dir_rows[5]  = '{4,    8'h01, 8'h01, 1, 0, 0, '{default: '0}};
    dir_rows[6]  = '{7,    8'h80, 8'h7F, 1, 1, 0, '{default: '0}};
    dir_rows[7]  = '{PAYLOAD_MAX, 8'hFF, 8'h00, 0, 0, 0, '{default: '0}};
    dir_rows[8]  = '{PAYLOAD_MAX + 1, 8'h00, 8'h01, 0, 0, 1,
                     '{11'd0, 16'd0, 16'd0, 11'd0, 16'd0, 1}};
    dir_rows[9]  = '{PAYLOAD_MAX + 8, 8'hFF, 8'h00, 1, 1, 1,
                     '{11'd0, 16'd0, 16'd0, 11'd0, 16'd0, 1}};
    dir_rows[10] = '{1,    8'h55, 8'h00, 0, 0, 0, '{default: '0}};
    dir_rows[11] = '{0,    8'h00, 8'h00, 1, 1, 0, '{default: '0}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_on  = dir_rows[i].typed;
      typed_res = dir_rows[i].want;
      send_packet(dir_rows[i].n, 1'b0, dir_rows[i].first, dir_rows[i].step,
                  dir_rows[i].empty_tail, dir_rows[i].gaps);
    end
    typed_on = 0;

    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(150);
    load_settings($urandom, $urandom, $urandom, $urandom);
    run_random(150);
    load_settings($urandom, $urandom, $urandom, $urandom);
    run_random(150);

    // a run of empty packets back to back
    load_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_0000);
    repeat (24) send_item(8'($urandom), 1'b0, 1'b1);
    run_random(150);

    load_settings($urandom, $urandom, $urandom, $urandom);
    quiet = 1;
    run_random(150);
    settle();
    repeat (16) @(posedge clk);

    if (pending_hdrs.size() != 0) begin
      $error("%0d results never arrived", pending_hdrs.size());
      err_cnt++;
    end
    $display("covered %0d packets (%0d oversize), %0d payload bytes, %0d register settings",
             pkt_cnt, over_cnt, items_sent, cfg_sets + 1);
    $display("identification wrapped %0d time(s), %0d results checked", wraps, hdrs_seen);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
